// ----- hw/rtl/dsmw_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual source merge weight package
// Shared types, register indexes and widths for the merge weight block.
// ----------------------------------------------------------------------------
package dsmw_pkg;

    localparam int TEXELS_Z = 1024;
    localparam int TEXELS_S = 512;

    localparam int COL_W  = 9;
    localparam int ROW_W  = 10;
    localparam int WGT_W  = 17;
    // Bounds and positions: |value| < 2^43 for any register contents.
    localparam int BND_W  = 44;
    localparam int QBIT_W = 17;
    localparam int ADDR_W = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);
    localparam logic [ROW_W-1:0] HALF_ROWS = ROW_W'(TEXELS_Z / 2);
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

    localparam logic [2:0] REG_END_OFFSET   = 3'd0;
    localparam logic [2:0] REG_END_SLOPE    = 3'd1;
    localparam logic [2:0] REG_START_OFFSET = 3'd2;
    localparam logic [2:0] REG_START_SLOPE  = 3'd3;
    localparam logic [2:0] REG_FIRST_ROW    = 3'd4;
    localparam logic [2:0] REG_ROW_STEP     = 3'd5;
    localparam logic [2:0] REG_MIN_START    = 3'd6;
    localparam logic [2:0] REG_MAX_END      = 3'd7;

    typedef enum logic [1:0] {
        REGION_BELOW = 2'd0,
        REGION_RAMP  = 2'd1,
        REGION_ABOVE = 2'd2
    } region_t;

    typedef struct packed {
        logic [COL_W-1:0] column_index;
        logic [ROW_W-1:0] row_index;
    } in_t;

    typedef struct packed {
        logic [WGT_W-1:0] weight;
        logic [1:0]       region;
    } out_t;

    typedef struct packed {
        logic signed [31:0] end_offset;
        logic signed [31:0] end_slope;
        logic signed [31:0] start_offset;
        logic signed [31:0] start_slope;
        logic signed [31:0] first_row_position;
        logic [30:0]        row_step;
        logic signed [31:0] min_mix_start;
        logic signed [31:0] max_mix_end;
    } cfg_t;

    typedef struct packed {
        region_t          region;
        logic [WGT_W-1:0] weight;
        logic [BND_W-1:0] num;
        logic [BND_W-1:0] den;
    } qentry_t;

    typedef struct packed {
        logic push;
        logic full;
    } qin_ctl_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } qout_ctl_t;

endpackage

// ----- hw/rtl/dual_source_merge_weight_top.sv -----
// ----------------------------------------------------------------------------
// Dual source merge weight top level
// Merge weight of the first X-ray source for one texel per request.
// ----------------------------------------------------------------------------
// One texel request is accepted every clock cycle while in_stall is low, and each
// gives exactly one result, in order. A front pipeline of three stages forms the
// column bounds, clamps them and classifies the row position; a four entry queue
// then feeds a back pipeline of eighteen stages, the first forming the dividend
// and each later one yielding one quotient bit of the rounded ramp division.
// Either side may stall on its own. The user must write the registers over the
// APB port only while no request is in flight; the block does not enforce this.
module dual_source_merge_weight_top
    import dsmw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_t              out_data
);

    cfg_t      cfg;
    qin_ctl_t  qin_ctl;
    qout_ctl_t qout_ctl;
    qentry_t   q_wr, q_rd;
    logic      q_full, q_empty;

    dsmw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dsmw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_ctl    (qin_ctl),
        .q_data   (q_wr)
    );

    dsmw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (qin_ctl),
        .wr_data (q_wr),
        .full    (q_full),
        .out_ctl (qout_ctl),
        .empty   (q_empty),
        .rd_data (q_rd)
    );

    dsmw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rd),
        .q_ctl     (qout_ctl),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- hw/rtl/dsmw_regs.sv -----
// ----------------------------------------------------------------------------
// Dual source merge weight configuration registers
// APB register file holding the mix geometry and clamp settings.
// ----------------------------------------------------------------------------
module dsmw_regs
    import dsmw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.end_offset         <= '0;
            cfg_reg.end_slope          <= '0;
            cfg_reg.start_offset       <= '0;
            cfg_reg.start_slope        <= '0;
            cfg_reg.first_row_position <= '0;
            cfg_reg.row_step           <= '0;
            cfg_reg.min_mix_start      <= S32_MIN;
            cfg_reg.max_mix_end        <= S32_MAX;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_END_OFFSET:   cfg_reg.end_offset         <= pwdata;
                REG_END_SLOPE:    cfg_reg.end_slope          <= pwdata;
                REG_START_OFFSET: cfg_reg.start_offset       <= pwdata;
                REG_START_SLOPE:  cfg_reg.start_slope        <= pwdata;
                REG_FIRST_ROW:    cfg_reg.first_row_position <= pwdata;
                REG_ROW_STEP:     cfg_reg.row_step           <= pwdata[30:0];
                REG_MIN_START:    cfg_reg.min_mix_start      <= pwdata;
                REG_MAX_END:      cfg_reg.max_mix_end        <= pwdata;
                default:          cfg_reg.end_offset         <= cfg_reg.end_offset;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_END_OFFSET:   prdata = cfg_reg.end_offset;
            REG_END_SLOPE:    prdata = cfg_reg.end_slope;
            REG_START_OFFSET: prdata = cfg_reg.start_offset;
            REG_START_SLOPE:  prdata = cfg_reg.start_slope;
            REG_FIRST_ROW:    prdata = cfg_reg.first_row_position;
            REG_ROW_STEP:     prdata = {1'b0, cfg_reg.row_step};
            REG_MIN_START:    prdata = cfg_reg.min_mix_start;
            REG_MAX_END:      prdata = cfg_reg.max_mix_end;
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/dsmw_front.sv -----
// ----------------------------------------------------------------------------
// Dual source merge weight front end
// Three stage pipeline: products, clamped bounds and row position, region.
// ----------------------------------------------------------------------------
module dsmw_front
    import dsmw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_t      in_data,
    input  logic     q_full,
    output qin_ctl_t q_ctl,
    output qentry_t  q_data
);

    logic advance;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    logic signed [BND_W-1:0] p_end_reg, p_start_reg, p_row_reg;
    logic                    s1_half_reg;
    logic signed [BND_W-1:0] end_reg, start_reg, z_reg;
    logic                    s2_half_reg;
    qentry_t                 entry_reg;

    logic signed [BND_W-1:0] col_x, row_x, step_x;
    logic signed [BND_W-1:0] end_raw, start_raw, z_raw;
    logic signed [BND_W-1:0] end_next, start_next;
    logic signed [BND_W-1:0] min_x, max_x;
    qentry_t                 entry_next;

    assign advance  = !(s3_valid_reg && q_full);
    assign in_stall = !advance;

    assign q_ctl.push = s3_valid_reg && !q_full;
    assign q_ctl.full = q_full;
    assign q_data     = entry_reg;

    assign col_x  = $signed({{(BND_W-COL_W){1'b0}}, in_data.column_index});
    assign row_x  = $signed({{(BND_W-ROW_W){1'b0}}, in_data.row_index});
    assign step_x = $signed({{(BND_W-31){1'b0}}, cfg.row_step});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage one: the three products.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_end_reg   <= BND_W'(cfg.end_slope) * col_x;
            p_start_reg <= BND_W'(cfg.start_slope) * col_x;
            p_row_reg   <= row_x * step_x;
            s1_half_reg <= in_data.row_index < HALF_ROWS;
        end
    end

    // Stage two: bounds, clamps and row position.
    always_comb
    begin
        min_x     = BND_W'(cfg.min_mix_start);
        max_x     = BND_W'(cfg.max_mix_end);
        end_raw   = BND_W'(cfg.end_offset) - p_end_reg;
        start_raw = p_start_reg - BND_W'(cfg.start_offset);
        z_raw     = BND_W'(cfg.first_row_position) + p_row_reg;
        start_next = start_raw;
        end_next   = end_raw;
        if (cfg.min_mix_start != S32_MIN && start_raw < min_x)
        begin
            start_next = min_x;
        end
        if (cfg.max_mix_end != S32_MAX && end_raw > max_x)
        begin
            end_next = max_x;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            end_reg     <= end_next;
            start_reg   <= start_next;
            z_reg       <= z_raw;
            s2_half_reg <= s1_half_reg;
        end
    end

    // Stage three: classify the texel and form the ramp operands.
    always_comb
    begin
        entry_next.num = BND_W'(end_reg - z_reg);
        entry_next.den = BND_W'(end_reg - start_reg);
        if (z_reg <= start_reg)
        begin
            entry_next.region = REGION_BELOW;
            entry_next.weight = s2_half_reg ? ONE_Q16 : '0;
        end
        else if (z_reg >= end_reg)
        begin
            entry_next.region = REGION_ABOVE;
            entry_next.weight = '0;
        end
        else
        begin
            entry_next.region = REGION_RAMP;
            entry_next.weight = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ----- hw/rtl/dsmw_queue.sv -----
// ----------------------------------------------------------------------------
// Dual source merge weight queue
// Small FIFO that decouples the front end from the divider back end.
// ----------------------------------------------------------------------------
module dsmw_queue
    import dsmw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  qin_ctl_t  in_ctl,
    input  qentry_t   wr_data,
    output logic      full,
    input  qout_ctl_t out_ctl,
    output logic      empty,
    output qentry_t   rd_data
);

    qentry_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full    = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (in_ctl.push && !out_ctl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!in_ctl.push && out_ctl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_ctl.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_ctl.pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ctl.push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointer distance must always agree with the fill count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == (QPTR_W+1)'(QUEUE_DEPTH)) || (count_reg == '0)
        || (QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0]))
        else $error("queue pointers disagree with fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ctl.push |-> !full || out_ctl.pop)
        else $error("queue written while full");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ctl.pop |-> !empty)
        else $error("queue read while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ctl.push && !out_ctl.pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fill count did not follow a push");

endmodule

// ----- hw/rtl/dsmw_back.sv -----
// ----------------------------------------------------------------------------
// Dual source merge weight back end
// Pipelined restoring divider for the ramp, one quotient bit per g_step stage.
// ----------------------------------------------------------------------------
module dsmw_back
    import dsmw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  qentry_t   q_data,
    output qout_ctl_t q_ctl,
    output logic      out_valid,
    input  logic      out_stall,
    output out_t      out_data
);

    localparam int NS = QBIT_W + 1;

    logic advance;
    logic pop;

    logic [NS-1:0]     valid_reg;
    logic [BND_W-1:0]  rem_reg  [NS];
    logic [BND_W-1:0]  den_reg  [NS];
    logic [QBIT_W-1:0] bits_reg [NS];
    logic [QBIT_W-1:0] quo_reg  [NS];
    region_t           reg_reg  [NS];
    logic [WGT_W-1:0]  fix_reg  [NS];

    logic [BND_W+QBIT_W-1:0] dividend;
    logic [WGT_W-1:0]        ramp_w;

    assign advance     = !(valid_reg[NS-1] && out_stall);
    assign pop         = advance && !q_empty;
    assign q_ctl.pop   = pop;
    assign q_ctl.empty = q_empty;

    // Rounded ramp: (num * 2^16 + den / 2) / den, with num < den.
    assign dividend = {q_data.num, 16'd0} + (BND_W+QBIT_W)'(q_data.den >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[NS-2:0], pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0]  <= dividend[BND_W+QBIT_W-1:QBIT_W];
            bits_reg[0] <= dividend[QBIT_W-1:0];
            den_reg[0]  <= q_data.den;
            quo_reg[0]  <= '0;
            reg_reg[0]  <= q_data.region;
            fix_reg[0]  <= q_data.weight;
        end
    end

    for (genvar k = 0; k < QBIT_W; k++)
    begin : g_step
        logic [BND_W:0] trial;
        logic [BND_W:0] diff;

        assign trial = {rem_reg[k], bits_reg[k][QBIT_W-1]};
        assign diff  = trial - {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (trial >= {1'b0, den_reg[k]})
                begin
                    rem_reg[k+1] <= diff[BND_W-1:0];
                    quo_reg[k+1] <= {quo_reg[k][QBIT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= trial[BND_W-1:0];
                    quo_reg[k+1] <= {quo_reg[k][QBIT_W-2:0], 1'b0};
                end
                bits_reg[k+1] <= {bits_reg[k][QBIT_W-2:0], 1'b0};
                den_reg[k+1]  <= den_reg[k];
                reg_reg[k+1]  <= reg_reg[k];
                fix_reg[k+1]  <= fix_reg[k];
            end
        end
    end

    assign ramp_w = (WGT_W'(quo_reg[NS-1]) > ONE_Q16) ? ONE_Q16 : WGT_W'(quo_reg[NS-1]);

    assign out_valid       = valid_reg[NS-1];
    assign out_data.region = reg_reg[NS-1];
    assign out_data.weight = (reg_reg[NS-1] == REGION_RAMP) ? ramp_w : fix_reg[NS-1];

endmodule
